### rtl/core/sqe_pkg.sv
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared codes and types for the stack/queue engine: opcodes, status codes,
// cell commands.
// ----------------------------------------------------------------------------
package sqe_pkg;

	localparam int unsigned DATA_W = 32;

	// opcodes
	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_PALL  = 3'd1;
	localparam logic [2:0] OP_PINT  = 3'd2;
	localparam logic [2:0] OP_SWAP  = 3'd3;
	localparam logic [2:0] OP_POP   = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_ARG    = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_PEEK_EMPTY = 3'd3;
	localparam logic [2:0] ST_SWAP_SHORT = 3'd4;
	localparam logic [2:0] ST_POP_EMPTY  = 3'd5;
	localparam logic [2:0] ST_HALTED     = 3'd6;

	// what every cell of the chain does this cycle
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1, // cell 0 takes the push value, others take left
		CELL_APPEND = 3'd2, // cell at index == count takes the push value
		CELL_REMOVE = 3'd3, // every cell takes right
		CELL_SWAP   = 3'd4, // cells 0 and 1 exchange
		CELL_ROTATE = 3'd5  // take right; cell count-1 takes cell 0
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   data;
	} cell_cmd_t;

endpackage

### rtl/core/sqe_cell.sv
// ----------------------------------------------------------------------------
// sqe_cell
// One entry of the store chain; position IDX counts from the front.
// ----------------------------------------------------------------------------
module sqe_cell import sqe_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 7
) (
	input  logic                clk,
	input  cell_cmd_t           cmd,
	input  logic [CW-1:0]       cnt,
	input  logic [DATA_W-1:0]   left,
	input  logic [DATA_W-1:0]   right,
	input  logic [DATA_W-1:0]   first,
	output logic [DATA_W-1:0]   q
);

	logic [DATA_W-1:0] data_q;
	logic              at_count;
	logic              at_tail;

	assign at_count = (cnt == CW'(IDX));
	assign at_tail  = (cnt == CW'(IDX + 1));

	// entry data carries no reset: unwritten entries are never read
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				data_q <= (IDX == 0) ? cmd.data : left;
			end
			CELL_APPEND: begin
				if (at_count) begin
					data_q <= cmd.data;
				end
			end
			CELL_REMOVE: begin
				data_q <= right;
			end
			CELL_SWAP: begin
				if (IDX == 0) begin
					data_q <= right;
				end else if (IDX == 1) begin
					data_q <= left;
				end
			end
			CELL_ROTATE: begin
				data_q <= at_tail ? first : right;
			end
			default: begin
			end
		endcase
	end

	assign q = data_q;

endmodule

### rtl/core/stack_queue_engine_core.sv
// ----------------------------------------------------------------------------
// stack_queue_engine_core
// Data stack of a small bytecode interpreter, with a queue mode for push.
// ----------------------------------------------------------------------------
//  channel  handshake            fields                                role
//  in       in_valid/in_ready    opcode, push_value, value_valid       request in
//  out      out_valid/out_ready  out_value, has_value, status, last    request out
//  cfg      cfg_we               cfg_wdata (queue_mode)                write only
//
//  Push, pop and swap shift or exchange the cell chain at the accepting edge,
//  and any result is written to the output register at that same edge.
//  Print-all rotates the occupied cells once per entry, emitting the front.
//  Input is taken only in idle while the output register is empty or being
//  drained, so a stall on out holds both the rotation and the input.
//  Reset clears count, halt flag, queue mode and out_valid, not the cell data.
// ----------------------------------------------------------------------------
module stack_queue_engine_core import sqe_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  push_value,
	input  logic                value_valid,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  out_value,
	output logic                has_value,
	output logic [2:0]          status,
	output logic                last
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_PRINT = 1'b1;

	logic              state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rem_q;
	logic              halted_q;
	logic              queue_mode_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              has_value_q;
	logic [2:0]        status_q;
	logic              last_q;

	logic [DATA_W-1:0] cell_q [DEPTH];
	cell_cmd_t         cmd;

	logic              slot_free;
	logic              accept;

	// next-state decisions
	logic              emit;
	logic [DATA_W-1:0] emit_value;
	logic              emit_has;
	logic [2:0]        emit_status;
	logic              emit_last;
	logic              fail;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     rem_d;
	logic              state_d;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd.op      = CELL_HOLD;
		cmd.data    = push_value;
		emit        = 1'b0;
		emit_value  = cell_q[0];
		emit_has    = 1'b0;
		emit_status = ST_OK;
		emit_last   = 1'b1;
		fail        = 1'b0;
		count_d     = count_q;
		rem_d       = rem_q;
		state_d     = state_q;

		if (state_q == S_PRINT) begin
			if (slot_free) begin
				// walk: emit front, rotate occupied part
				cmd.op    = CELL_ROTATE;
				emit      = 1'b1;
				emit_has  = 1'b1;
				emit_last = (rem_q == CW'(1));
				rem_d     = rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					state_d = S_IDLE;
				end
			end
		end else if (accept) begin
			if (halted_q) begin
				emit        = 1'b1;
				emit_status = ST_HALTED;
			end else begin
				case (opcode)
					OP_PUSH: begin
						if (count_q >= CW'(DEPTH)) begin
							fail        = 1'b1;
							emit_status = ST_FULL;
						end else if (!value_valid) begin
							fail        = 1'b1;
							emit_status = ST_BAD_ARG;
						end else begin
							cmd.op  = queue_mode_q ? CELL_APPEND : CELL_INSERT;
							count_d = count_q + CW'(1);
						end
					end
					OP_PALL: begin
						if (count_q != '0) begin
							cmd.op    = CELL_ROTATE;
							emit      = 1'b1;
							emit_has  = 1'b1;
							emit_last = (count_q == CW'(1));
							rem_d     = count_q - CW'(1);
							if (count_q != CW'(1)) begin
								state_d = S_PRINT;
							end
						end
					end
					OP_PINT: begin
						if (count_q == '0) begin
							fail        = 1'b1;
							emit_status = ST_PEEK_EMPTY;
						end else begin
							emit     = 1'b1;
							emit_has = 1'b1;
						end
					end
					OP_SWAP: begin
						if (count_q < CW'(2)) begin
							fail        = 1'b1;
							emit_status = ST_SWAP_SHORT;
						end else begin
							cmd.op = CELL_SWAP;
						end
					end
					OP_POP: begin
						if (count_q == '0) begin
							fail        = 1'b1;
							emit_status = ST_POP_EMPTY;
						end else begin
							cmd.op  = CELL_REMOVE;
							count_d = count_q - CW'(1);
						end
					end
					default: begin
						// unused opcodes are dropped silently
					end
				endcase
				if (fail) begin
					emit    = 1'b1;
					count_d = '0;
				end
			end
		end
		if (!emit_has) begin
			emit_value = '0;
		end
	end

	// store chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_head
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_q[i+1];
		end
		sqe_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.cnt   (count_q),
			.left  (left_d),
			.right (right_d),
			.first (cell_q[0]),
			.q     (cell_q[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rem_q        <= '0;
			halted_q     <= 1'b0;
			queue_mode_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (fail) begin
				halted_q <= 1'b1;
			end
			if (cfg_we) begin
				queue_mode_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= emit_value;
			has_value_q <= emit_has;
			status_q    <= emit_status;
			last_q      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign has_value = has_value_q;
	assign status    = status_q;
	assign last      = last_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_halt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (count_q == '0))
		else $error("halted with entries left");

	a_print_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRINT) |-> (rem_q != '0 && rem_q < count_q))
		else $error("print walk counter out of range");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free)
		else $error("result written over a pending result");

	a_fail_halts: assert property (@(posedge clk) disable iff (!arst_n)
		fail |=> (halted_q && count_q == '0))
		else $error("error did not halt and empty the store");

endmodule

### sim/stack_queue_engine_core_test.sv
// ----------------------------------------------------------------------------
// stack_queue_engine_core_test
// Self-checking bench for the stack/queue engine. A shadow copy of the store
// predicts the results of each accepted request, and every result leaving the
// block is compared field by field with the oldest prediction. A short table
// of directed requests runs first, then random phases that alternate the push
// mode, and finally a run into one error and the halted state behind it.
// ----------------------------------------------------------------------------
module stack_queue_engine_core_test;
	import sqe_pkg::*;

	localparam int STORE_DEPTH    = 64;
	localparam int PHASE_REQUESTS = 95;   // non-ignored requests per random phase
	localparam int HALTED_TAIL    = 16;   // requests sent after the block halts
	localparam int LONG_HOLD      = 400;  // cycles of the long receiver stall
	localparam int SETTLE_CYCLES  = 6;    // quiet time after the last result
	localparam int WATCHDOG_LIMIT = 4000; // cycles with no handshake at all
	localparam int SCRIPT_ROWS    = 25;

	// opcodes the block decodes to nothing
	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [31:0] word;
		logic        has_word;
		logic [2:0]  code;
		logic        tail;
	} result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] word;
		logic        arg_ok;
		logic        typed;   // want holds the one result, written by hand
		result_t     want;
	} request_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_THROTTLE} rx_mode_t;
	typedef enum int {
		END_FULL, END_BAD_ARG, END_PEEK_EMPTY, END_SWAP_SHORT, END_POP_EMPTY
	} halt_cause_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic        cfg_wdata   = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode      = OP_PUSH;
	logic [31:0] push_value  = '0;
	logic        value_valid = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [31:0] out_value;
	logic        has_value;
	logic [2:0]  status;
	logic        last;

	stack_queue_engine_core #(.DEPTH(STORE_DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.push_value  (push_value),
		.value_valid (value_valid),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.has_value   (has_value),
		.status      (status),
		.last        (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow store: ring of words addressed by a front index and a count.
	// ------------------------------------------------------------------------
	logic [31:0] shadow_words [0:STORE_DEPTH-1];
	logic [5:0]  shadow_front;
	logic [6:0]  shadow_count;
	logic        shadow_halted;
	logic        shadow_queue_mode;

	result_t step_results [$];   // results of the request just accepted
	result_t awaited_results [$];

	int n_fail        = 0;
	int burst_left    = 0;
	int hold_requests = 0;       // bumped by the stimulus, served by the receiver

	task automatic halt_shadow(input logic [2:0] code);
		step_results.push_back('{32'd0, 1'b0, code, 1'b1});
		shadow_count  = '0;
		shadow_front  = '0;
		shadow_halted = 1'b1;
	endtask

	task automatic step_shadow_stack(input request_t rq);
		logic [5:0]  a;
		logic [5:0]  b;
		logic [31:0] t;
		step_results.delete();
		if (shadow_halted) begin
			step_results.push_back('{32'd0, 1'b0, ST_HALTED, 1'b1});
		end else begin
			case (rq.op)
				OP_PUSH: begin
					// full is checked first, so it wins over a bad argument
					if (shadow_count >= STORE_DEPTH) begin
						halt_shadow(ST_FULL);
					end else if (!rq.arg_ok) begin
						halt_shadow(ST_BAD_ARG);
					end else begin
						if (shadow_queue_mode) begin
							a = shadow_front + shadow_count[5:0];
							shadow_words[a] = rq.word;
						end else begin
							shadow_front = shadow_front - 6'd1;
							shadow_words[shadow_front] = rq.word;
						end
						shadow_count = shadow_count + 7'd1;
					end
				end
				OP_PALL: begin
					for (int k = 0; k < shadow_count; k++) begin
						a = shadow_front + 6'(k);
						step_results.push_back('{shadow_words[a], 1'b1, ST_OK,
							(k + 1 == shadow_count)});
					end
				end
				OP_PINT: begin
					if (shadow_count == 0) begin
						halt_shadow(ST_PEEK_EMPTY);
					end else begin
						step_results.push_back('{shadow_words[shadow_front], 1'b1, ST_OK,
							1'b1});
					end
				end
				OP_SWAP: begin
					if (shadow_count < 2) begin
						halt_shadow(ST_SWAP_SHORT);
					end else begin
						a = shadow_front;
						b = shadow_front + 6'd1;
						t = shadow_words[a];
						shadow_words[a] = shadow_words[b];
						shadow_words[b] = t;
					end
				end
				OP_POP: begin
					if (shadow_count == 0) begin
						halt_shadow(ST_POP_EMPTY);
					end else begin
						shadow_front = shadow_front + 6'd1;
						shadow_count = shadow_count - 7'd1;
					end
				end
				default: begin
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	function automatic request_t make_request(input logic [2:0] op,
			input logic [31:0] word, input logic arg_ok);
		return '{op, word, arg_ok, 1'b0, '0};
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// Holds valid until accepted, then predicts. Valid stays up inside a burst
	// and drops for a random gap at its end.
	task automatic offer_request(input request_t rq);
		int gap;
		opcode      <= rq.op;
		push_value  <= rq.word;
		value_valid <= rq.arg_ok;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		step_shadow_stack(rq);
		if (rq.typed) begin
			awaited_results.push_back(rq.want);
		end else begin
			foreach (step_results[i]) awaited_results.push_back(step_results[i]);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender pause: nothing offered until every predicted result is back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_queue_mode(input logic mode);
		cfg_wdata <= mode;
		cfg_we    <= 1'b1;
		@(posedge clk);
		shadow_queue_mode = mode;
		cfg_we <= 1'b0;
	endtask

	// Well-formed random request: never drives the store into an error.
	// A few spare opcodes are mixed in as noise.
	function automatic request_t pick_request(input int push_pct);
		int         r;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		if (r < 5)                  op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		else if (r < 5 + push_pct)  op = OP_PUSH;
		else if (r < 15 + push_pct) op = OP_PALL;
		else if (r < 23 + push_pct) op = OP_PINT;
		else if (r < 31 + push_pct) op = OP_SWAP;
		else                        op = OP_POP;
		if (op == OP_PUSH && shadow_count == STORE_DEPTH)
			op = OP_POP;
		if (((op == OP_PINT || op == OP_POP) && shadow_count == 0) ||
				(op == OP_SWAP && shadow_count < 2))
			op = OP_PUSH;
		if (op >= OP_SPARE_LO)
			return make_request(op, pick_word(), 1'($urandom_range(0, 1)));
		return make_request(op, pick_word(), 1'b1);
	endfunction

	// Directed table; rows with typed set carry their one result by hand.
	request_t warmup_rows [0:SCRIPT_ROWS-1];

	initial begin
		warmup_rows = '{
			'{OP_PALL,      32'h0000_0000, 1'b1, 1'b0, '0},  // empty: no result
			'{OP_PUSH,      32'h7fff_ffff, 1'b1, 1'b0, '0},
			'{OP_PINT,      32'h0000_0000, 1'b1, 1'b1,
				'{32'h7fff_ffff, 1'b1, ST_OK, 1'b1}},
			'{OP_PUSH,      32'h8000_0000, 1'b1, 1'b0, '0},
			'{OP_PINT,      32'h0000_0000, 1'b1, 1'b1,
				'{32'h8000_0000, 1'b1, ST_OK, 1'b1}},
			'{OP_PUSH,      32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_PUSH,      32'hffff_ffff, 1'b1, 1'b0, '0},
			'{OP_PALL,      32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_SWAP,      32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_PINT,      32'h0000_0000, 1'b1, 1'b1,
				'{32'h0000_0000, 1'b1, ST_OK, 1'b1}},
			'{OP_SPARE_LO,  32'hffff_ffff, 1'b0, 1'b0, '0},  // ignored
			'{OP_SPARE_MID, 32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_SPARE_HI,  32'h8000_0000, 1'b0, 1'b0, '0},
			'{OP_POP,       32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_PINT,      32'h0000_0000, 1'b1, 1'b1,
				'{32'hffff_ffff, 1'b1, ST_OK, 1'b1}},
			'{OP_PALL,      32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_POP,       32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_POP,       32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_POP,       32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_PUSH,      32'h5a5a_5a5a, 1'b1, 1'b0, '0},
			'{OP_PUSH,      32'ha5a5_a5a5, 1'b1, 1'b0, '0},
			'{OP_SWAP,      32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_PALL,      32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_POP,       32'h0000_0000, 1'b1, 1'b0, '0},
			'{OP_POP,       32'h0000_0000, 1'b1, 1'b0, '0}
		};
	end

	initial begin
		int          sent;
		int          push_pct;
		halt_cause_t cause;
		request_t    rq;

		for (int i = 0; i < STORE_DEPTH; i++) shadow_words[i] = '0;
		shadow_front      = '0;
		shadow_count      = '0;
		shadow_halted     = 1'b0;
		shadow_queue_mode = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_queue_mode(1'b0);

		foreach (warmup_rows[i]) offer_request(warmup_rows[i]);
		wait_for_results();

		// random phases, push mode 1, 0, 1, 0
		for (int phase = 0; phase < 4; phase++) begin
			set_queue_mode(phase % 2 == 0);
			push_pct = $urandom_range(30, 60);
			sent = 0;
			if (phase == 1) begin
				// long receiver stall while the store fills and is dumped,
				// so the block backs up and holds off its input
				hold_requests <= hold_requests + 1;
				while (shadow_count < STORE_DEPTH) begin
					offer_request(make_request(OP_PUSH, pick_word(), 1'b1));
					sent++;
				end
				offer_request(make_request(OP_PALL, pick_word(), 1'b1));
				sent++;
			end
			while (sent < PHASE_REQUESTS) begin
				rq = pick_request(push_pct);
				offer_request(rq);
				if (rq.op < OP_SPARE_LO) sent++;
			end
			wait_for_results();
		end

		// one error, then random requests of any opcode in the halted state
		cause = halt_cause_t'($urandom_range(0, 4));
		case (cause)
			END_FULL: begin
				while (shadow_count < STORE_DEPTH)
					offer_request(make_request(OP_PUSH, pick_word(), 1'b1));
				offer_request(make_request(OP_PUSH, pick_word(),
					1'($urandom_range(0, 1))));
			end
			END_BAD_ARG: begin
				if (shadow_count == STORE_DEPTH)
					offer_request(make_request(OP_POP, pick_word(), 1'b1));
				offer_request(make_request(OP_PUSH, pick_word(), 1'b0));
			end
			END_SWAP_SHORT: begin
				while (shadow_count > 1)
					offer_request(make_request(OP_POP, pick_word(), 1'b1));
				offer_request(make_request(OP_SWAP, pick_word(), 1'b1));
			end
			default: begin
				while (shadow_count > 0)
					offer_request(make_request(OP_POP, pick_word(), 1'b1));
				offer_request(make_request((cause == END_PEEK_EMPTY) ? OP_PINT : OP_POP,
					pick_word(), 1'b1));
			end
		endcase
		for (int i = 0; i < HALTED_TAIL; i++)
			offer_request(make_request(3'($urandom_range(0, 7)), pick_word(),
				1'($urandom_range(0, 1))));

		wait_for_results();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: receiver stall pattern and checker
	// ------------------------------------------------------------------------
	rx_mode_t rx_mode      = RX_OPEN;
	int       rx_seg_left  = 0;
	int       rx_hold_left = 0;
	int       rx_holds     = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			out_ready <= 1'b0;
			rx_hold_left--;
		end else if (rx_holds != hold_requests) begin
			rx_holds++;
			rx_hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			if (rx_seg_left == 0) begin
				rx_mode     = rx_mode_t'($urandom_range(0, 2));
				rx_seg_left = $urandom_range(4, 40);
			end else begin
				rx_seg_left--;
			end
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= (rx_seg_left % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with none pending: out_value %0d status %0d",
					$signed(out_value), status);
				n_fail++;
			end else begin
				want = awaited_results.pop_front();
				if (out_value !== want.word) begin
					$error("out_value: expected %0d, got %0d", $signed(want.word),
						$signed(out_value));
					n_fail++;
				end
				if (has_value !== want.has_word) begin
					$error("has_value: expected %0d, got %0d", want.has_word, has_value);
					n_fail++;
				end
				if (status !== want.code) begin
					$error("status: expected %0d, got %0d", want.code, status);
					n_fail++;
				end
				if (last !== want.tail) begin
					$error("last: expected %0d, got %0d", want.tail, last);
					n_fail++;
				end
			end
		end
	end

	// Watchdog: too long without a handshake on either side.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

### stack_queue_engine_core.f
rtl/core/sqe_pkg.sv
rtl/core/sqe_cell.sv
rtl/core/stack_queue_engine_core.sv
sim/stack_queue_engine_core_test.sv
